// ===== rtl/string_bucket_hash_macros.svh =====
// Assertion macros shared by the RTL. Clock aclk, reset aresetn (active low).
`ifndef STRING_BUCKET_HASH_MACROS_SVH
`define STRING_BUCKET_HASH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbh_pkg.sv =====
`default_nettype none
package sbh_pkg;

    localparam int unsigned CFG_W        = 32;
    localparam int unsigned KEY_W        = 8;
    localparam int unsigned OUT_FIELD_W  = 32;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 32'd1024;

    // shift distances of the mixing and finalisation rounds
    localparam logic [3:0] SHL_MIX = 4'd10;
    localparam logic [3:0] SHR_MIX = 4'd6;
    localparam logic [3:0] SHL_FIN_A = 4'd3;
    localparam logic [3:0] SHR_FIN = 4'd11;
    localparam logic [3:0] SHL_FIN_B = 4'd15;

    typedef logic [2:0] step_t;
    localparam step_t STEP_MIX_FIRST = 3'd0;
    localparam step_t STEP_MIX_LAST  = 3'd2;
    localparam step_t STEP_FIN_FIRST = 3'd3;
    localparam step_t STEP_FIN_LAST  = 3'd5;

    typedef enum logic [1:0] {
        OP_ADD_BYTE,
        OP_ADD_SHL,
        OP_XOR_SHR
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [3:0] shamt;
    } alu_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic alu_ctrl_t step_ctrl(input step_t step);
        alu_ctrl_t c;
        c.op    = OP_ADD_SHL;
        c.shamt = 4'd0;
        case (step)
            3'd0: begin c.op = OP_ADD_BYTE; c.shamt = 4'd0;      end
            3'd1: begin c.op = OP_ADD_SHL;  c.shamt = SHL_MIX;   end
            3'd2: begin c.op = OP_XOR_SHR;  c.shamt = SHR_MIX;   end
            3'd3: begin c.op = OP_ADD_SHL;  c.shamt = SHL_FIN_A; end
            3'd4: begin c.op = OP_XOR_SHR;  c.shamt = SHR_FIN;   end
            3'd5: begin c.op = OP_ADD_SHL;  c.shamt = SHL_FIN_B; end
            default: begin c.op = OP_ADD_SHL; c.shamt = 4'd0;    end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sbh_alu.sv =====
`default_nettype none
// Shared shift/add/xor unit: one hash round per cycle.
module sbh_alu #(
    parameter int unsigned HASH_WIDTH = 32
) (
    input  wire sbh_pkg::alu_ctrl_t         ctrl,
    input  wire logic [HASH_WIDTH-1:0]      hash_in,
    input  wire logic [sbh_pkg::KEY_W-1:0]  key_byte,
    output logic      [HASH_WIDTH-1:0]      hash_out
);

    logic [HASH_WIDTH-1:0] addend;

    always_comb begin
        addend = hash_in << ctrl.shamt;
        if (ctrl.op == sbh_pkg::OP_ADD_BYTE) begin
            addend = {{(HASH_WIDTH-sbh_pkg::KEY_W){1'b0}}, key_byte};
        end
        case (ctrl.op)
            sbh_pkg::OP_ADD_BYTE,
            sbh_pkg::OP_ADD_SHL: hash_out = hash_in + addend;
            sbh_pkg::OP_XOR_SHR: hash_out = hash_in ^ (hash_in >> ctrl.shamt);
            default:             hash_out = hash_in;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/sbh_div.sv =====
`default_nettype none
// Restoring remainder unit, one dividend bit per cycle, MSB first.
module sbh_div #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [WIDTH-1:0]                  dividend,
    input  wire logic [sbh_pkg::CFG_W-1:0]         divisor,
    output logic                                   done,
    output logic      [sbh_pkg::CFG_W-1:0]         remainder
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [WIDTH-1:0]            dvd_reg, dvd_next;
    logic [sbh_pkg::CFG_W-1:0]   dvs_reg, dvs_next;
    logic [sbh_pkg::CFG_W-1:0]   rem_reg, rem_next;
    logic                        done_reg, done_next;
    logic [sbh_pkg::CFG_W:0]     trial;
    logic [sbh_pkg::CFG_W:0]     diff;

    always_comb begin
        trial     = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = CNT_W'(WIDTH);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = dvd_reg << 1;
            // remainder stays below the divisor, so the top bit drops out
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[sbh_pkg::CFG_W-1:0]
                                                  : trial[sbh_pkg::CFG_W-1:0];
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/string_bucket_hash.sv =====
`default_nettype none
// One-at-a-time string hash with bucket selection. Key bytes arrive one per
// transaction on the s_ channel (tuser marks a byte as present, a zero byte
// counts as absent, tlast ends the key). A single shift/add/xor unit runs the
// hash rounds under a step sequencer, one round per cycle: a key byte is
// accepted and then runs the three mixing rounds before s_tready returns, an
// item with no byte and no tlast leaves s_tready high. On tlast the three
// finalisation rounds follow, then the restoring remainder unit is started
// and works through the hash one dividend bit at a time, MSB first; once it
// reports done the result is loaded into the output register. A result still
// waiting in the output register when the next key ends holds the block until
// it is taken. The output register lets the next key begin while a result
// waits. m_tdata carries the bucket index (hash modulo bucket_count) and the
// finalised hash; with bucket_count zero the index equals the hash.
// bucket_count resets to 1024 and is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce.
`include "string_bucket_hash_macros.svh"
module string_bucket_hash #(
    parameter int unsigned HASH_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // bucket_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] key_byte
    input  wire logic        s_tuser,       // [0] has_byte
    input  wire logic        s_tlast,       // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata        // [31:0] bucket_index, [63:32] hash_value
);

    sbh_pkg::state_t              state_reg, state_next;
    sbh_pkg::step_t               step_reg, step_next;
    logic                         last_reg, last_next;
    logic [sbh_pkg::KEY_W-1:0]    byte_reg, byte_next;
    logic [HASH_WIDTH-1:0]        hash_reg, hash_next;
    logic [sbh_pkg::CFG_W-1:0]    bucket_count_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [63:0]                  m_tdata_reg, m_tdata_next;

    sbh_pkg::alu_ctrl_t           alu_ctrl;
    logic [HASH_WIDTH-1:0]        alu_out;
    logic                         div_start;
    logic                         div_done;
    logic [sbh_pkg::CFG_W-1:0]    div_rem;
    logic                         s_accept;
    logic                         has_mix;
    logic                         out_free;
    logic                         in_div;
    logic                         out_load;
    logic [sbh_pkg::OUT_FIELD_W-1:0] hash_low;
    logic [sbh_pkg::OUT_FIELD_W-1:0] bucket_idx;

    sbh_alu #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_alu (
        .ctrl     (alu_ctrl),
        .hash_in  (hash_reg),
        .key_byte (byte_reg),
        .hash_out (alu_out)
    );

    sbh_div #(
        .WIDTH (HASH_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hash_reg),
        .divisor   (bucket_count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign s_tready   = (state_reg == sbh_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign has_mix    = s_tuser && (s_tdata != '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_div     = (state_reg == sbh_pkg::ST_DIV);
    assign out_load   = (state_reg == sbh_pkg::ST_OUT) && out_free;
    assign alu_ctrl   = sbh_pkg::step_ctrl(step_reg);
    assign hash_low   = hash_reg[sbh_pkg::OUT_FIELD_W-1:0];
    assign bucket_idx = (bucket_count_reg == '0) ? hash_low : div_rem;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        last_next     = last_reg;
        byte_next     = byte_reg;
        hash_next     = hash_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sbh_pkg::ST_IDLE: begin
                if (s_accept) begin
                    byte_next = s_tdata;
                    last_next = s_tlast;
                    if (has_mix) begin
                        step_next  = sbh_pkg::STEP_MIX_FIRST;
                        state_next = sbh_pkg::ST_STEP;
                    end else if (s_tlast) begin
                        step_next  = sbh_pkg::STEP_FIN_FIRST;
                        state_next = sbh_pkg::ST_STEP;
                    end
                end
            end
            sbh_pkg::ST_STEP: begin
                hash_next = alu_out;
                step_next = step_reg + 1'b1;
                if (step_reg == sbh_pkg::STEP_MIX_LAST && !last_reg) begin
                    state_next = sbh_pkg::ST_IDLE;
                end else if (step_reg == sbh_pkg::STEP_FIN_LAST) begin
                    state_next = sbh_pkg::ST_DIV;
                end
            end
            sbh_pkg::ST_DIV: begin
                // start fires on entry: the remainder unit is idle until then
                div_start = (step_reg != sbh_pkg::STEP_MIX_FIRST);
                step_next = sbh_pkg::STEP_MIX_FIRST;
                if (div_done) begin
                    state_next = sbh_pkg::ST_OUT;
                end
            end
            sbh_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {hash_low, bucket_idx};
                    hash_next     = '0;
                    state_next    = sbh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sbh_pkg::ST_IDLE;
            step_reg         <= sbh_pkg::STEP_MIX_FIRST;
            hash_reg         <= '0;
            bucket_count_reg <= sbh_pkg::BUCKET_COUNT_RESET;
            m_tvalid_reg     <= 1'b0;
            last_reg         <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            hash_reg     <= hash_next;
            m_tvalid_reg <= m_tvalid_next;
            last_reg     <= last_next;
            if (cfg_wr_en) begin
                bucket_count_reg <= cfg_wr_data;
            end
        end
        byte_reg    <= byte_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SBH_ASSERT_SAME(a_done_in_div, div_done, in_div, "remainder done outside division")
    `SBH_ASSERT_NEXT(a_noop_item, s_accept && !s_tlast && !has_mix, s_tready, "empty item stuck")
    `SBH_ASSERT_NEXT(a_out_load, out_load, m_tvalid && hash_reg == '0, "result not loaded")
    `SBH_ASSERT_NEXT(a_div_start, div_start, !div_start && in_div, "division restarted")

endmodule
`default_nettype wire

// ===== bench/string_bucket_hash_test.sv =====
module string_bucket_hash_test;

    typedef struct packed {
        logic [sbh_pkg::OUT_FIELD_W-1:0] hash_value;
        logic [sbh_pkg::OUT_FIELD_W-1:0] bucket_index;
    } hash_result_t;

    localparam int unsigned HASH_W     = 32;
    localparam int unsigned DRAIN_TAIL = 48;   // outlasts the processing of a last item
    localparam int unsigned PHASE_ITEMS = 425;

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [sbh_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [sbh_pkg::KEY_W-1:0]     s_tdata     = '0;   // [7:0] key_byte
    logic                          s_tuser     = 1'b0; // [0] has_byte
    logic                          s_tlast     = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [2*sbh_pkg::OUT_FIELD_W-1:0] m_tdata;   // [31:0] bucket_index, [63:32] hash_value

    int unsigned                   send_idle_pct  = 0;
    int unsigned                   recv_stall_pct = 0;
    int unsigned                   errors         = 0;

    logic [HASH_W-1:0]             hash_state     = '0;
    logic [sbh_pkg::CFG_W-1:0]     bucket_divisor = sbh_pkg::BUCKET_COUNT_RESET;
    hash_result_t                  expected_hashes[$];

    string_bucket_hash i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [HASH_W-1:0] mix_key_byte(input logic [HASH_W-1:0] h,
                                                       input logic [sbh_pkg::KEY_W-1:0] kb);
        logic [HASH_W-1:0] t;
        t = h + HASH_W'(kb);
        t = t + (t << sbh_pkg::SHL_MIX);
        t = t ^ (t >> sbh_pkg::SHR_MIX);
        return t;
    endfunction

    function automatic logic [HASH_W-1:0] finalise_hash(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << sbh_pkg::SHL_FIN_A);
        t = t ^ (t >> sbh_pkg::SHR_FIN);
        t = t + (t << sbh_pkg::SHL_FIN_B);
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Sends one item and updates the expected hash on acceptance.
    // s_tvalid stays high between back-to-back items; it drops only for a gap.
    task automatic send_item(input logic [sbh_pkg::KEY_W-1:0] kb, input logic has,
                             input logic is_last);
        hash_result_t r;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kb;
        s_tuser  <= has;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        // a zero byte is a terminator, not a key byte
        if (has && kb != '0)
            hash_state = mix_key_byte(hash_state, kb);
        if (is_last) begin
            r.hash_value   = finalise_hash(hash_state);
            r.bucket_index = (bucket_divisor == '0) ? r.hash_value
                                                    : r.hash_value % bucket_divisor;
            expected_hashes.push_back(r);
            hash_state = '0;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_bucket_count(input logic [sbh_pkg::CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        bucket_divisor  = value;
    endtask

    // Mostly ordinary keys of 1..8 bytes, some long ones, some empty; zero
    // bytes and byte-less items are sprinkled in as noise.
    task automatic send_random_key(output int unsigned sent);
        int unsigned len;
        int unsigned pick;
        int unsigned kind;
        logic [sbh_pkg::KEY_W-1:0] kb;
        sent = 0;
        pick = $urandom_range(99);
        if (pick < 8)
            len = 0;
        else if (pick < 90)
            len = $urandom_range(1, 8);
        else
            len = $urandom_range(9, 40);
        if (len == 0) begin
            kb = sbh_pkg::KEY_W'($urandom_range(255));
            if ($urandom_range(1)) send_item(8'h00, 1'b1, 1'b1);
            else                   send_item(kb, 1'b0, 1'b1);
            sent = 1;
        end else begin
            for (int unsigned i = 0; i < len; i++) begin
                kind = $urandom_range(99);
                kb   = sbh_pkg::KEY_W'($urandom_range(255));
                if (kind < 6)
                    send_item(8'h00, 1'b1, i == len - 1);
                else if (kind < 12)
                    send_item(kb, 1'b0, i == len - 1);
                else
                    send_item(sbh_pkg::KEY_W'($urandom_range(1, 255)), 1'b1, i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_directed_keys();
        send_item(8'h00, 1'b0, 1'b1);     // empty key
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);     // terminator only: same as empty
        send_item(8'h5A, 1'b0, 1'b0);     // byte-less items must not mix
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_bucket_extremes();
        logic [sbh_pkg::CFG_W-1:0] counts[3];
        counts = '{32'd1, 32'hFFFF_FFFF, 32'd0};
        foreach (counts[i]) begin
            write_bucket_count(counts[i]);
            send_item(8'h7F, 1'b1, 1'b0);
            send_item(sbh_pkg::KEY_W'($urandom_range(1, 255)), 1'b1, 1'b1);
            wait_idle();
        end
    endtask

    task automatic test_random_keys(input int unsigned send_pct, input int unsigned stall_pct,
                                    input logic [sbh_pkg::CFG_W-1:0] count);
        int unsigned total;
        int unsigned sent;
        total          = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        write_bucket_count(count);
        while (total < PHASE_ITEMS) begin
            send_random_key(sent);
            total += sent;
        end
        wait_idle();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_result
        hash_result_t exp_r;
        hash_result_t got_r;
        if (aresetn && m_tvalid && m_tready) begin
            got_r = m_tdata;
            if (expected_hashes.size() == 0) begin
                report_mismatch($sformatf("result with none pending: %h", m_tdata));
            end else begin
                exp_r = expected_hashes.pop_front();
                if (got_r.bucket_index !== exp_r.bucket_index)
                    report_mismatch($sformatf("bucket_index %h, want %h",
                                              got_r.bucket_index, exp_r.bucket_index));
                if (got_r.hash_value !== exp_r.hash_value)
                    report_mismatch($sformatf("hash_value %h, want %h",
                                              got_r.hash_value, exp_r.hash_value));
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_keys();
        test_bucket_extremes();
        test_random_keys(0, 0, sbh_pkg::CFG_W'($urandom_range(2, 4096)));
        test_random_keys(65, 0, 32'h8000_0000);
        test_random_keys(0, 65, sbh_pkg::CFG_W'($urandom));
        test_random_keys(19, 19, sbh_pkg::CFG_W'($urandom_range(1, 16)));
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
